@@ design/olist_pkg.sv @@
// shared types, constants and codes of the ordered list engine
package olist_pkg;

   // field widths
   localparam int VALUE_W      = 32;
   localparam int CMD_W        = 3;
   localparam int POS_W        = 6;
   localparam int STATUS_W     = 2;
   localparam int MPOS_W       = 5;
   localparam int LEN_W        = 6;

   // sizing defaults
   localparam int CAPACITY_DEF = 32;
   localparam int MAX_OUT      = 32;

   // command codes
   localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

   // input item
   typedef struct packed {
      logic [CMD_W-1:0]          command;
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]          position;
   } req_type;

   // result item
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                found;
      logic [MPOS_W-1:0]   match_position;
      logic                last;
      logic [LEN_W-1:0]    length;
      logic                empty_res;
   } rsp_type;

   // action broadcast to the cell row
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_REMOVE = 2'd2
   } cell_op_type;

   typedef struct packed {
      cell_op_type               op;
      logic signed [VALUE_W-1:0] value;
   } cell_ctl_type;

endpackage

@@ design/olist_cell.sv @@
// one list entry: holds a value, shifts with its neighbors and compares
module olist_cell
   import olist_pkg::*;
#(
   parameter int CNT_W = 6,
   parameter int INDEX = 0
) (
   input  logic                      clock,
   input  cell_ctl_type              ctl,
   input  logic [CNT_W-1:0]          pos,
   input  logic [CNT_W-1:0]          count,
   input  logic signed [VALUE_W-1:0] left_data,
   input  logic signed [VALUE_W-1:0] right_data,
   output logic signed [VALUE_W-1:0] data,
   output logic                      match
);

   localparam logic [CNT_W-1:0] IDX      = CNT_W'(INDEX);
   localparam logic [CNT_W-1:0] IDX_NEXT = CNT_W'(INDEX + 1);

   logic signed [VALUE_W-1:0] data_ff;
   logic signed [VALUE_W-1:0] data_in;

   // pick own value, neighbor's value or the new value
   always_comb begin
      data_in = data_ff;
      case (ctl.op)
         CELL_INSERT: begin
            if (IDX == pos) begin
               data_in = ctl.value;
            end else if (IDX > pos && IDX <= count) begin
               data_in = left_data;
            end
         end
         CELL_REMOVE: begin
            if (IDX >= pos && IDX_NEXT < count) begin
               data_in = right_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // live entry equal to the searched value
   assign data  = data_ff;
   assign match = (IDX < count) && (data_ff == ctl.value);

endmodule

@@ design/olist_drain.sv @@
// walks the captured match flags and hands out one position per cycle while step is high
module olist_drain
   import olist_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  logic                        step,
   input  logic [CAPACITY-1:0]         match_vec,
   output logic [$clog2(CAPACITY)-1:0] cur_pos,
   output logic                        cur_last
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int OUT_W = $clog2(MAX_OUT);
   localparam logic [OUT_W-1:0] OUT_LAST = OUT_W'(MAX_OUT - 1);

   logic [CAPACITY-1:0] pend_ff;
   logic [CAPACITY-1:0] pend_in;
   logic [OUT_W-1:0]    emit_ff;
   logic [OUT_W-1:0]    emit_in;
   logic [CAPACITY-1:0] low_bit;
   logic [CAPACITY-1:0] rest;

   // isolate the lowest pending match
   assign low_bit = pend_ff & (~pend_ff + {{(CAPACITY-1){1'b0}}, 1'b1});
   assign rest    = pend_ff & ~low_bit;

   // encode the one-hot position
   always_comb begin
      cur_pos = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (low_bit[i]) begin
            cur_pos = cur_pos | IDX_W'(i);
         end
      end
   end

   assign cur_last = (rest == '0) || (emit_ff == OUT_LAST);

   // pending flags and emitted count
   always_comb begin
      pend_in = pend_ff;
      emit_in = emit_ff;
      if (load) begin
         pend_in = match_vec;
         emit_in = '0;
      end else if (step) begin
         pend_in = cur_last ? '0 : rest;
         emit_in = emit_ff + OUT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         emit_ff <= '0;
      end else begin
         pend_ff <= pend_in;
         emit_ff <= emit_in;
      end
   end

endmodule

@@ design/ordered_list_engine.sv @@
// ordered list engine: one item per command, a row of cells holds the list
// results come from the result register, loaded in exec or drain; busy is high outside idle
// a command is taken only in idle, after the last is done; a search drains its matches
// each command makes a single shift or compare pass in the cell row in the exec state
// reset clears the entry count and control; stored values need no reset
// results cannot be stalled: each strobes for exactly one cycle
module ordered_list_engine
   import olist_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_EXEC  = 3'b010,
      S_DRAIN = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   req_type             req_ff, req_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   cell_ctl_type        cell_ctl;
   logic [CNT_W-1:0]    cell_pos;
   logic signed [VALUE_W-1:0] cell_data [CAPACITY];
   logic [CAPACITY-1:0] match_vec;

   logic [CMP_W-1:0]    cnt_c, pos_c, ins_pos;
   logic                drain_load, drain_step, drain_last;
   logic [IDX_W-1:0]    drain_pos;

   assign busy    = (state_ff != S_IDLE);
   assign cnt_c   = CMP_W'(count_ff);
   assign pos_c   = CMP_W'(req_ff.position);
   assign ins_pos = (req_ff.command == CMD_APPEND) ? cnt_c : pos_c;

   // row of cells
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [VALUE_W-1:0] left_d, right_d;
      if (g == 0) begin : g_head
         assign left_d = '0;
      end else begin : g_body
         assign left_d = cell_data[g-1];
      end
      if (g == CAPACITY - 1) begin : g_tail
         assign right_d = '0;
      end else begin : g_inner
         assign right_d = cell_data[g+1];
      end
      olist_cell #(
         .CNT_W (CNT_W),
         .INDEX (g)
      ) u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .pos        (cell_pos),
         .count      (count_ff),
         .left_data  (left_d),
         .right_data (right_d),
         .data       (cell_data[g]),
         .match      (match_vec[g])
      );
   end

   // match walker for search
   olist_drain #(
      .CAPACITY (CAPACITY)
   ) u_drain (
      .clock     (clock),
      .reset     (reset),
      .load      (drain_load),
      .step      (drain_step),
      .match_vec (match_vec),
      .cur_pos   (drain_pos),
      .cur_last  (drain_last)
   );

   // command decode, cell control and result
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      count_in      = count_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      cell_ctl.op   = CELL_HOLD;
      cell_ctl.value = req_ff.value;
      cell_pos      = CNT_W'(ins_pos);
      drain_load    = 1'b0;
      drain_step    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_item;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            rsp_valid_in          = 1'b1;
            rsp_in.status         = ST_OK;
            rsp_in.found          = 1'b0;
            rsp_in.match_position = '0;
            rsp_in.last           = 1'b1;
            state_in              = S_IDLE;
            case (req_ff.command)
               CMD_APPEND, CMD_INSERT: begin
                  if (cnt_c >= CAP_C) begin
                     rsp_in.status = ST_FULL;
                  end else if (ins_pos > cnt_c) begin
                     rsp_in.status = ST_RANGE;
                  end else begin
                     cell_ctl.op = CELL_INSERT;
                     count_in    = count_ff + CNT_W'(1);
                  end
               end
               CMD_REMOVE: begin
                  cell_pos = CNT_W'(pos_c);
                  if (pos_c >= cnt_c) begin
                     rsp_in.status = ST_RANGE;
                  end else begin
                     cell_ctl.op = CELL_REMOVE;
                     count_in    = count_ff - CNT_W'(1);
                  end
               end
               CMD_SEARCH: begin
                  if (count_ff == '0) begin
                     rsp_in.status = ST_EMPTY;
                  end else if (match_vec != '0) begin
                     drain_load   = 1'b1;
                     rsp_valid_in = 1'b0;
                     state_in     = S_DRAIN;
                  end
               end
               CMD_CLEAR: begin
                  count_in = '0;
               end
               default: begin
                  rsp_in.status = ST_OK;
               end
            endcase
         end
         S_DRAIN: begin
            drain_step            = 1'b1;
            rsp_valid_in          = 1'b1;
            rsp_in.status         = ST_OK;
            rsp_in.found          = 1'b1;
            rsp_in.match_position = MPOS_W'(drain_pos);
            rsp_in.last           = drain_last;
            if (drain_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_in.length    = LEN_W'(count_in);
      rsp_in.empty_res = (count_in == '0);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

`ifndef NO_ASSERTIONS
   // a result only follows a cycle of work
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without preceding work");

   // the entry count stays within the cell row
   assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CAP_C)
      else $error("entry count beyond capacity");

   // more results to come means the engine is still draining
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.last |-> busy && state_ff == S_DRAIN)
      else $error("non-final result while not draining");

   // a match is always reported with ok status
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.found |-> rsp_item.status == ST_OK)
      else $error("match reported with error status");
`endif

endmodule
